[rtl/trap_pkg.sv]
package trap_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_AW    = 3;

    // widths of the query datapath, all but CAP_W derived from the fraction width
    localparam int VM_W  = 63 - FRAC_BITS;
    localparam int SUM_W = VM_W + 1;
    localparam int MAG_W = SUM_W + 1;
    localparam int POS_W = SUM_W + 2;
    localparam int SHR_K = 2 * FRAC_BITS + 1;
    localparam int RQ_W  = 95 - SHR_K;
    localparam int CAP_W = 41;

    localparam logic [CFG_AW-1:0] REG_START = 3'd0;
    localparam logic [CFG_AW-1:0] REG_END   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SPEED = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ACCEL = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DECEL = 3'd4;

    typedef logic [1:0] t_seg;
    localparam t_seg SEG_ACCEL  = 2'd0;
    localparam t_seg SEG_CRUISE = 2'd1;
    localparam t_seg SEG_DECEL  = 2'd2;

    function automatic logic [31:0] sat_u32(input logic [63:0] x);
        return (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [POS_W-1:0] x);
        logic signed [POS_W-1:0] hi_lim;
        logic signed [POS_W-1:0] lo_lim;
        hi_lim = POS_W'(64'sh0000_0000_7FFF_FFFF);
        lo_lim = POS_W'(-64'sh0000_0000_8000_0000);
        if (x > hi_lim) begin
            return 32'h7FFF_FFFF;
        end else if (x < lo_lim) begin
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

[rtl/trapezoidal_motion_profile.sv]
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[31:0] query_time
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[31:0] position, [63:32] velocity,
//                                             [64] finished, [71:65] zero
// cfg       in   i_cfg_we (no wait)           i_cfg_addr register index, i_cfg_data value
//
// one query per cycle unless a rebuild runs or the output stalls
// a write to registers 0 to 4 rebuilds the profile on a shared 64-step divider,
// a 32x32 multiplier and, for a triangle, a 32-step square root; s_axis_tready
// stays low meanwhile
// synchronous active-low reset gives the zero-distance profile at once
// the whole query pipeline holds while m_axis_tvalid is high and m_axis_tready low
module trapezoidal_motion_profile (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [trap_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [31:0]                 i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [31:0] query_time
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [71:0]                 m_axis_tdata    // position, velocity, finished
);
    import trap_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_INIT = 5'd1;
    localparam logic [4:0] ST_MUL  = 5'd2;
    localparam logic [4:0] ST_DIV  = 5'd3;
    localparam logic [4:0] ST_SQ   = 5'd4;
    localparam logic [4:0] ST_VV   = 5'd5;
    localparam logic [4:0] ST_RA   = 5'd6;
    localparam logic [4:0] ST_RD   = 5'd7;
    localparam logic [4:0] ST_FAT  = 5'd8;
    localparam logic [4:0] ST_FDT  = 5'd9;
    localparam logic [4:0] ST_FCT  = 5'd10;
    localparam logic [4:0] ST_TQ   = 5'd11;
    localparam logic [4:0] ST_TH   = 5'd12;
    localparam logic [4:0] ST_TM   = 5'd13;
    localparam logic [4:0] ST_TM1  = 5'd14;
    localparam logic [4:0] ST_TP   = 5'd15;
    localparam logic [4:0] ST_TSP  = 5'd16;
    localparam logic [4:0] ST_TAT  = 5'd17;
    localparam logic [4:0] ST_TDT  = 5'd18;
    localparam logic [4:0] ST_TSS  = 5'd19;
    localparam logic [4:0] ST_TAD  = 5'd20;
    localparam logic [4:0] ST_FIN  = 5'd21;

    localparam logic [40:0] CAP_VAL = 41'h100_0000_0000;

    // configuration
    logic [31:0] r_start;
    logic [31:0] r_end;
    logic [30:0] r_spd_lim;
    logic [30:0] r_acc_lim;
    logic [30:0] r_dec_lim;

    // derived profile
    logic [31:0] r_acc_dur;
    logic [31:0] r_cru_dur;
    logic [31:0] r_tot_dur;
    logic [31:0] r_scs;
    logic [30:0] r_cr_spd;
    logic [31:0] r_acc_dist;
    logic [31:0] r_cru_dist;

    // sequencer
    logic [4:0]  r_state;
    logic [4:0]  r_ret;
    logic [31:0] r_ma;
    logic [31:0] r_mb;
    logic [63:0] r_prod;
    logic [63:0] r_dq;
    logic [32:0] r_drem;
    logic [32:0] r_dden;
    logic [5:0]  r_dcnt;
    logic [63:0] r_sn;
    logic [63:0] r_sr;
    logic [63:0] r_sbit;
    logic [61:0] r_vv;
    logic [61:0] r_ra;
    logic [61:0] r_rd;
    logic [30:0] r_h;
    logic [63:0] r_m1;
    logic [31:0] r_m2;
    logic [31:0] r_dtd;

    logic [30:0] w_v;
    logic [30:0] w_a;
    logic [30:0] w_d;
    logic [31:0] w_s;
    logic signed [32:0] w_diff;
    logic [32:0] w_dabs;
    logic [31:0] w_dist;
    logic        w_neg;
    logic [33:0] w_dsh;
    logic        w_dge;
    logic [33:0] w_dsub;
    logic [64:0] w_strial;
    logic        w_sge;
    logic [30:0] w_sq_spd;
    logic        w_m2ge;
    logic [31:0] w_cd;
    logic [62:0] w_rsum;

    assign w_v    = (r_spd_lim == 31'd0) ? 31'd1 : r_spd_lim;
    assign w_a    = (r_acc_lim == 31'd0) ? 31'd1 : r_acc_lim;
    assign w_d    = (r_dec_lim == 31'd0) ? 31'd1 : r_dec_lim;
    assign w_s    = {1'b0, w_a} + {1'b0, w_d};
    assign w_diff = $signed({r_end[31], r_end}) - $signed({r_start[31], r_start});
    assign w_dabs = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_dist = w_dabs[31:0];
    assign w_neg  = !($signed(r_end) > $signed(r_start));

    assign w_dsh  = {r_drem, r_dq[63]};
    assign w_dge  = w_dsh >= {1'b0, r_dden};
    assign w_dsub = w_dsh - {1'b0, r_dden};

    assign w_strial = {1'b0, r_sr} + {1'b0, r_sbit};
    assign w_sge    = {1'b0, r_sn} >= w_strial;
    assign w_sq_spd = (r_sr > {33'd0, w_v}) ? w_v : r_sr[30:0];
    assign w_m2ge   = {1'b0, r_m2, 1'b0} >= {2'b0, w_s};
    assign w_cd     = w_dist - r_ra[31:0] - r_rd[31:0];
    assign w_rsum   = {1'b0, r_ra} + {1'b0, r_dq[61:0]};

    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= 32'd0;
            r_end      <= 32'd0;
            r_spd_lim  <= 31'd131072;
            r_acc_lim  <= 31'd65536;
            r_dec_lim  <= 31'd98304;
            r_acc_dur  <= 32'd0;
            r_cru_dur  <= 32'd0;
            r_tot_dur  <= 32'd0;
            r_scs      <= 32'd0;
            r_cr_spd   <= 31'd0;
            r_acc_dist <= 32'd0;
            r_cru_dist <= 32'd0;
            r_state    <= ST_IDLE;
            r_ret      <= ST_IDLE;
            r_dcnt     <= 6'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_START: r_start   <= i_cfg_data;
                    REG_END:   r_end     <= i_cfg_data;
                    REG_SPEED: r_spd_lim <= i_cfg_data[30:0];
                    REG_ACCEL: r_acc_lim <= i_cfg_data[30:0];
                    REG_DECEL: r_dec_lim <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_cfg_we && (i_cfg_addr <= REG_DECEL)) begin
                r_state <= ST_INIT;
            end else begin
                case (r_state)
                    ST_IDLE: ;
                    ST_INIT: begin
                        if (w_dist == 32'd0) begin
                            r_acc_dur  <= 32'd0;
                            r_cru_dur  <= 32'd0;
                            r_tot_dur  <= 32'd0;
                            r_scs      <= 32'd0;
                            r_cr_spd   <= 31'd0;
                            r_acc_dist <= 32'd0;
                            r_cru_dist <= 32'd0;
                            r_state    <= ST_IDLE;
                        end else begin
                            r_ma    <= {1'b0, w_v};
                            r_mb    <= {1'b0, w_v};
                            r_ret   <= ST_VV;
                            r_state <= ST_MUL;
                        end
                    end
                    ST_MUL: r_state <= r_ret;
                    ST_DIV: begin
                        r_drem <= w_dge ? w_dsub[32:0] : w_dsh[32:0];
                        r_dq   <= {r_dq[62:0], w_dge};
                        r_dcnt <= r_dcnt + 6'd1;
                        if (r_dcnt == 6'd63) begin
                            r_state <= r_ret;
                        end
                    end
                    ST_SQ: begin
                        if (w_sge) begin
                            r_sn <= r_sn - w_strial[63:0];
                            r_sr <= (r_sr >> 1) + r_sbit;
                        end else begin
                            r_sr <= r_sr >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                        if (r_sbit[0]) begin
                            r_state <= ST_TSP;
                        end
                    end
                    ST_VV: begin
                        r_vv    <= r_prod[61:0];
                        r_dq    <= {2'b0, r_prod[61:0]};
                        r_drem  <= 33'd0;
                        r_dden  <= {1'b0, w_a, 1'b0};
                        r_dcnt  <= 6'd0;
                        r_ret   <= ST_RA;
                        r_state <= ST_DIV;
                    end
                    ST_RA: begin
                        r_ra    <= r_dq[61:0];
                        r_dq    <= {2'b0, r_vv};
                        r_drem  <= 33'd0;
                        r_dden  <= {1'b0, w_d, 1'b0};
                        r_dcnt  <= 6'd0;
                        r_ret   <= ST_RD;
                        r_state <= ST_DIV;
                    end
                    ST_RD: begin
                        r_rd <= r_dq[61:0];
                        if (w_rsum <= {31'd0, w_dist}) begin
                            r_dq    <= 64'({w_v, {FRAC_BITS{1'b0}}});
                            r_drem  <= 33'd0;
                            r_dden  <= {2'b0, w_a};
                            r_dcnt  <= 6'd0;
                            r_ret   <= ST_FAT;
                            r_state <= ST_DIV;
                        end else begin
                            r_ma    <= {1'b0, w_a};
                            r_mb    <= {1'b0, w_d};
                            r_ret   <= ST_TQ;
                            r_state <= ST_MUL;
                        end
                    end
                    ST_FAT: begin
                        r_acc_dur <= sat_u32(r_dq);
                        r_dq      <= 64'({w_v, {FRAC_BITS{1'b0}}});
                        r_drem    <= 33'd0;
                        r_dden    <= {2'b0, w_d};
                        r_dcnt    <= 6'd0;
                        r_ret     <= ST_FDT;
                        r_state   <= ST_DIV;
                    end
                    ST_FDT: begin
                        r_dtd      <= sat_u32(r_dq);
                        r_acc_dist <= r_ra[31:0];
                        r_cru_dist <= w_cd;
                        r_cr_spd   <= w_v;
                        r_dq       <= 64'({w_cd, {FRAC_BITS{1'b0}}});
                        r_drem     <= 33'd0;
                        r_dden     <= {2'b0, w_v};
                        r_dcnt     <= 6'd0;
                        r_ret      <= ST_FCT;
                        r_state    <= ST_DIV;
                    end
                    ST_FCT: begin
                        r_cru_dur <= sat_u32(r_dq);
                        r_state   <= ST_FIN;
                    end
                    ST_TQ: begin
                        r_dq    <= r_prod;
                        r_drem  <= 33'd0;
                        r_dden  <= {1'b0, w_s};
                        r_dcnt  <= 6'd0;
                        r_ret   <= ST_TH;
                        r_state <= ST_DIV;
                    end
                    ST_TH: begin
                        r_h     <= r_dq[30:0];
                        r_ma    <= w_dist;
                        r_mb    <= r_drem[31:0];
                        r_ret   <= ST_TM;
                        r_state <= ST_MUL;
                    end
                    ST_TM: begin
                        r_dq    <= r_prod;
                        r_drem  <= 33'd0;
                        r_dden  <= {1'b0, w_s};
                        r_dcnt  <= 6'd0;
                        r_ret   <= ST_TM1;
                        r_state <= ST_DIV;
                    end
                    ST_TM1: begin
                        r_m1    <= r_dq;
                        r_m2    <= r_drem[31:0];
                        r_ma    <= w_dist;
                        r_mb    <= {1'b0, r_h};
                        r_ret   <= ST_TP;
                        r_state <= ST_MUL;
                    end
                    ST_TP: begin
                        r_sn    <= {r_prod[62:0], 1'b0} + {r_m1[62:0], 1'b0} + 64'(w_m2ge);
                        r_sr    <= 64'd0;
                        r_sbit  <= 64'h4000_0000_0000_0000;
                        r_state <= ST_SQ;
                    end
                    ST_TSP: begin
                        r_cr_spd <= w_sq_spd;
                        r_dq     <= 64'({w_sq_spd, {FRAC_BITS{1'b0}}});
                        r_drem   <= 33'd0;
                        r_dden   <= {2'b0, w_a};
                        r_dcnt   <= 6'd0;
                        r_ret    <= ST_TAT;
                        r_state  <= ST_DIV;
                    end
                    ST_TAT: begin
                        r_acc_dur <= sat_u32(r_dq);
                        r_dq      <= 64'({r_cr_spd, {FRAC_BITS{1'b0}}});
                        r_drem    <= 33'd0;
                        r_dden    <= {2'b0, w_d};
                        r_dcnt    <= 6'd0;
                        r_ret     <= ST_TDT;
                        r_state   <= ST_DIV;
                    end
                    ST_TDT: begin
                        r_dtd   <= sat_u32(r_dq);
                        r_ma    <= {1'b0, r_cr_spd};
                        r_mb    <= {1'b0, r_cr_spd};
                        r_ret   <= ST_TSS;
                        r_state <= ST_MUL;
                    end
                    ST_TSS: begin
                        r_dq    <= r_prod;
                        r_drem  <= 33'd0;
                        r_dden  <= {1'b0, w_a, 1'b0};
                        r_dcnt  <= 6'd0;
                        r_ret   <= ST_TAD;
                        r_state <= ST_DIV;
                    end
                    ST_TAD: begin
                        r_acc_dist <= sat_u32(r_dq);
                        r_cru_dist <= 32'd0;
                        r_cru_dur  <= 32'd0;
                        r_state    <= ST_FIN;
                    end
                    ST_FIN: begin
                        r_tot_dur <= sat_u32(64'({2'b0, r_acc_dur} + {2'b0, r_cru_dur}
                                                 + {2'b0, r_dtd}));
                        r_scs     <= w_neg ? 32'(-{1'b0, r_cr_spd}) : {1'b0, r_cr_spd};
                        r_state   <= ST_IDLE;
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end

    // query pipeline
    logic        w_en;
    logic        r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_ov;
    logic [31:0] r_a_t;
    t_seg        r_b_seg, r_c_seg, r_d_seg, r_e_seg;
    logic        r_b_fin, r_c_fin, r_d_fin, r_e_fin, r_f_fin;
    logic [31:0] r_b_x, r_c_x;
    logic [30:0] r_b_coef;
    logic [62:0] r_c_m1;
    logic [62:0] r_c_sv;
    logic [63:0] r_d_lo;
    logic [62:0] r_d_hi;
    logic [VM_W-1:0] r_d_vm, r_d_sv, r_e_vm;
    logic [CAP_W-1:0] r_e_r;
    logic [SUM_W-1:0] r_e_sum;
    logic signed [MAG_W-1:0] r_f_mag;
    logic signed [MAG_W-1:0] r_f_vel;
    logic [31:0] r_o_pos;
    logic [31:0] r_o_vel;
    logic        r_o_fin;

    logic [32:0] w_cend;
    logic        w_b_fin, w_b_acc, w_b_cru;
    t_seg        w_b_seg;
    logic [31:0] w_b_x;
    logic [94:0] w_full;
    logic [RQ_W-1:0] w_rq;
    logic [CAP_W-1:0] w_rcap;
    logic signed [MAG_W-1:0] w_vm_s;
    logic signed [MAG_W-1:0] w_scs_s;
    logic signed [POS_W-1:0] w_pos;
    logic signed [POS_W-1:0] w_vel;

    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en && (r_state == ST_IDLE);

    assign w_cend  = {1'b0, r_acc_dur} + {1'b0, r_cru_dur};
    assign w_b_fin = r_a_t >= r_tot_dur;
    assign w_b_acc = r_a_t <= r_acc_dur;
    assign w_b_cru = {1'b0, r_a_t} <= w_cend;

    always_comb begin
        if (w_b_acc) begin
            w_b_seg = SEG_ACCEL;
            w_b_x   = r_a_t;
        end else if (w_b_cru) begin
            w_b_seg = SEG_CRUISE;
            w_b_x   = r_a_t - r_acc_dur;
        end else begin
            w_b_seg = SEG_DECEL;
            w_b_x   = r_a_t - w_cend[31:0];
        end
    end

    assign w_full = {r_d_hi, 32'd0} + {31'd0, r_d_lo};
    assign w_rq   = w_full[94:SHR_K];
    assign w_rcap = (w_rq > RQ_W'(CAP_VAL)) ? CAP_VAL : w_rq[CAP_W-1:0];

    assign w_vm_s  = $signed({2'b0, r_e_vm});
    assign w_scs_s = MAG_W'($signed(r_scs));

    assign w_pos = $signed({{(POS_W-32){r_start[31]}}, r_start})
                 + (w_neg ? -POS_W'(r_f_mag) : POS_W'(r_f_mag));
    assign w_vel = POS_W'(r_f_vel);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_t <= s_axis_tdata;

            r_b_fin  <= w_b_fin;
            r_b_seg  <= w_b_seg;
            r_b_x    <= w_b_x;
            r_b_coef <= (w_b_seg == SEG_DECEL) ? w_d : w_a;

            r_c_m1  <= r_b_coef * r_b_x;
            r_c_sv  <= r_cr_spd * r_b_x;
            r_c_x   <= r_b_x;
            r_c_seg <= r_b_seg;
            r_c_fin <= r_b_fin;

            r_d_lo  <= r_c_m1[31:0] * r_c_x;
            r_d_hi  <= r_c_m1[62:32] * r_c_x;
            r_d_vm  <= r_c_m1[62:FRAC_BITS];
            r_d_sv  <= r_c_sv[62:FRAC_BITS];
            r_d_seg <= r_c_seg;
            r_d_fin <= r_c_fin;

            r_e_r   <= w_rcap;
            r_e_sum <= SUM_W'(r_acc_dist) + SUM_W'(r_d_seg == SEG_DECEL ? r_cru_dist : 32'd0)
                     + SUM_W'(r_d_sv);
            r_e_vm  <= r_d_vm;
            r_e_seg <= r_d_seg;
            r_e_fin <= r_d_fin;

            case (r_e_seg)
                SEG_ACCEL: begin
                    r_f_mag <= MAG_W'(r_e_r);
                    r_f_vel <= w_neg ? -w_vm_s : w_vm_s;
                end
                SEG_CRUISE: begin
                    r_f_mag <= $signed({1'b0, r_e_sum});
                    r_f_vel <= w_scs_s;
                end
                default: begin
                    r_f_mag <= $signed({1'b0, r_e_sum}) - MAG_W'(r_e_r);
                    r_f_vel <= w_neg ? w_scs_s + w_vm_s : w_scs_s - w_vm_s;
                end
            endcase
            r_f_fin <= r_e_fin;

            r_o_fin <= r_f_fin;
            r_o_pos <= r_f_fin ? r_end : sat_s32(w_pos);
            r_o_vel <= r_f_fin ? 32'd0 : sat_s32(w_vel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_va <= s_axis_tvalid && s_axis_tready;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_vf <= r_ve;
            r_ov <= r_vf;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_o_fin, r_o_vel, r_o_pos};

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> r_state == ST_IDLE)
        else $error("query taken while profile rebuild runs");

    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_addr <= REG_DECEL) |=> r_state == ST_INIT)
        else $error("register write did not restart the profile rebuild");

    a_fin_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[63:32] == 32'd0)
        else $error("finished result with nonzero velocity");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) && (w_dist == 32'd0) |-> r_tot_dur == 32'd0)
        else $error("zero distance profile has nonzero duration");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import trap_pkg::*;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] velocity;
        logic        finished;
    } motion_t;

    localparam int LATENCY   = 7;
    localparam int WDOG_MAX  = 20000;
    localparam longint unsigned CAP = 64'd1 << 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_AW-1:0]    i_cfg_addr;
    logic [31:0]          i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [71:0]          m_axis_tdata;

    // profile copy
    logic signed [31:0]   cur_start;
    logic signed [31:0]   cur_end;
    logic [30:0]          cur_speed;
    logic [30:0]          cur_accel;
    logic [30:0]          cur_decel;
    logic [31:0]          accel_dur;
    logic [31:0]          cruise_dur;
    logic [31:0]          total_dur;
    logic signed [31:0]   cruise_speed;
    logic [31:0]          accel_dist;
    logic [31:0]          cruise_dist;

    logic [31:0] query_q[$];
    motion_t     motion_q[$];
    int          errors;
    int          wdog;
    bit          quiet;

    trapezoidal_motion_profile DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] clip_u32(longint unsigned x);
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function automatic logic [31:0] clip_s32(longint x);
        if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (x < -64'sh8000_0000) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // floor(m*t / 2^(2F+1)) capped at 2^40
    function automatic longint unsigned ramp_area(longint unsigned m, logic [31:0] t);
        logic [127:0] full;
        full = (128'(m) * 128'(t)) >> (2 * FRAC_BITS + 1);
        return (full > 128'(CAP)) ? CAP : full[63:0];
    endfunction

    function automatic void build_profile();
        longint          delta;
        longint unsigned dd, v, a, d, ra, rd, dt, spd, s, q, h, qr, m, m1, m2, p;
        delta = longint'(cur_end) - longint'(cur_start);
        dd = (delta < 0) ? -delta : delta;
        v = (cur_speed != 0) ? cur_speed : 1;
        a = (cur_accel != 0) ? cur_accel : 1;
        d = (cur_decel != 0) ? cur_decel : 1;
        accel_dur = 0;
        cruise_dur = 0;
        total_dur = 0;
        cruise_speed = 0;
        accel_dist = 0;
        cruise_dist = 0;
        if (dd == 0) return;
        ra = (v * v) / (2 * a);
        rd = (v * v) / (2 * d);
        if (ra + rd <= dd) begin
            spd = v;
            accel_dur = clip_u32((v << FRAC_BITS) / a);
            dt = (v << FRAC_BITS) / d;
            accel_dist = ra[31:0];
            cruise_dist = 32'(dd - ra - rd);
            cruise_dur = clip_u32((64'(cruise_dist) << FRAC_BITS) / v);
        end else begin
            s = a + d;
            q = a * d;
            h = q / s;
            qr = q % s;
            m = dd * qr;
            m1 = m / s;
            m2 = m % s;
            p = 2 * dd * h + 2 * m1 + (2 * m2) / s;
            spd = root64(p);
            if (spd > v) spd = v;
            accel_dur = clip_u32((spd << FRAC_BITS) / a);
            dt = (spd << FRAC_BITS) / d;
            accel_dist = clip_u32((spd * spd) / (2 * a));
        end
        total_dur = clip_u32(64'(accel_dur) + 64'(cruise_dur) + 64'(clip_u32(dt)));
        cruise_speed = (delta > 0) ? 32'(spd) : -32'(spd);
    endfunction

    function automatic motion_t predict_motion(logic [31:0] t);
        motion_t         r;
        longint          dir, pos, vel, mag;
        longint unsigned a, d, spd, cend, at, ddt;
        logic [31:0]     ct;
        a = (cur_accel != 0) ? cur_accel : 1;
        d = (cur_decel != 0) ? cur_decel : 1;
        dir = (cur_end > cur_start) ? 1 : -1;
        spd = (cruise_speed < 0) ? -longint'(cruise_speed) : longint'(cruise_speed);
        cend = 64'(accel_dur) + 64'(cruise_dur);
        if (t >= total_dur) begin
            r.position = cur_end;
            r.velocity = 0;
            r.finished = 1'b1;
            return r;
        end
        if (t <= accel_dur) begin
            at = a * 64'(t);
            vel = dir * longint'(at >> FRAC_BITS);
            pos = longint'(cur_start) + dir * longint'(ramp_area(at, t));
        end else if (64'(t) <= cend) begin
            ct = t - accel_dur;
            pos = longint'(cur_start) + dir * (longint'(accel_dist)
                  + longint'((spd * 64'(ct)) >> FRAC_BITS));
            vel = cruise_speed;
        end else begin
            ct = 32'(64'(t) - cend);
            ddt = d * 64'(ct);
            mag = longint'(accel_dist) + longint'(cruise_dist)
                  + longint'((spd * 64'(ct)) >> FRAC_BITS) - longint'(ramp_area(ddt, ct));
            vel = longint'(cruise_speed) - dir * longint'(ddt >> FRAC_BITS);
            pos = longint'(cur_start) + dir * mag;
        end
        r.position = clip_s32(pos);
        r.velocity = clip_s32(vel);
        r.finished = 1'b0;
        return r;
    endfunction

    // query driver, predicts each transfer as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                motion_q.push_back(predict_motion(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (query_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 17)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= query_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        motion_t got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 17);
            if (m_axis_tvalid && m_axis_tready) begin
                got.position = m_axis_tdata[31:0];
                got.velocity = m_axis_tdata[63:32];
                got.finished = m_axis_tdata[64];
                if (motion_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = motion_q.pop_front();
                    if (got.position !== want.position) begin
                        $display("%0t: position exp %h got %h", $time,
                                 want.position, got.position);
                        errors++;
                    end
                    if (got.velocity !== want.velocity) begin
                        $display("%0t: velocity exp %h got %h", $time,
                                 want.velocity, got.velocity);
                        errors++;
                    end
                    if (got.finished !== want.finished) begin
                        $display("%0t: finished exp %b got %b", $time,
                                 want.finished, got.finished);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !i_rst_n) begin
            wdog <= 0;
        end else if (wdog >= WDOG_MAX) begin
            $display("** trapezoidal_motion_profile: FAILED **");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    task automatic drain();
        do @(posedge i_clk);
        while (query_q.size() > 0 || s_axis_tvalid || motion_q.size() > 0);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_profile(logic [31:0] st, logic [31:0] en, logic [31:0] v,
                                logic [31:0] a, logic [31:0] d);
        drain();
        write_reg(REG_START, st);
        write_reg(REG_END, en);
        write_reg(REG_SPEED, v);
        write_reg(REG_ACCEL, a);
        write_reg(REG_DECEL, d);
        i_cfg_we <= 1'b0;
        cur_start = st;
        cur_end = en;
        cur_speed = v[30:0];
        cur_accel = a[30:0];
        cur_decel = d[30:0];
        build_profile();
        repeat (2) @(posedge i_clk);
    endtask

    task automatic push_edges();
        logic [31:0] ce;
        ce = 32'(64'(accel_dur) + 64'(cruise_dur));
        query_q.push_back(0);
        query_q.push_back(accel_dur);
        query_q.push_back(accel_dur + 1);
        query_q.push_back(ce);
        query_q.push_back(ce + 1);
        query_q.push_back(total_dur - 1);
        query_q.push_back(total_dur);
    endtask

    function automatic logic [31:0] pick_limit();
        logic [31:0] r;
        case ($urandom_range(0, 7))
            0: r = 0;
            1: r = 32'h7FFF_FFFF;
            2: r = $urandom_range(1, 255);
            3: r = $urandom;
            default: r = $urandom_range(1 << 14, 1 << 20);
        endcase
        r[31] = $urandom_range(0, 1);
        return r;
    endfunction

    function automatic logic [31:0] pick_time();
        longint unsigned hi;
        logic [31:0]     ce;
        ce = 32'(64'(accel_dur) + 64'(cruise_dur));
        hi = 64'(total_dur) + (64'(total_dur) >> 3) + 2;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        case ($urandom_range(0, 19))
            0, 1: return $urandom;
            2: return accel_dur + $urandom_range(0, 2) - 1;
            3: return ce + $urandom_range(0, 2) - 1;
            4: return total_dur + $urandom_range(0, 2) - 1;
            default: return $urandom_range(0, 32'(hi));
        endcase
    endfunction

    initial begin
        logic [31:0] st, en;
        errors = 0;
        quiet = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cur_start = 0;
        cur_end = 0;
        cur_speed = 31'd131072;
        cur_accel = 31'd65536;
        cur_decel = 31'd98304;
        build_profile();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero distance after reset
        query_q.push_back(0);
        query_q.push_back(32'hFFFF_FFFF);

        load_profile(32'h0001_0000, 32'h0005_0000, 32'h0002_0000, 32'h0001_0000,
                     32'h0001_8000);
        push_edges();
        load_profile(32'h0005_0000, 32'h0000_0000, 32'h0010_0000, 32'h0001_0000,
                     32'h0002_0000);
        push_edges();
        load_profile(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF);
        query_q.push_back(1);
        query_q.push_back(total_dur >> 1);
        query_q.push_back(32'hFFFF_FFFF);
        load_profile(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        query_q.push_back(0);
        query_q.push_back(32'h0000_8000);
        query_q.push_back($urandom);

        for (int ph = 0; ph < 28; ph++) begin
            st = $urandom;
            case ($urandom_range(0, 3))
                0: en = $urandom;
                1: en = st;
                default: en = st + $urandom_range(0, 1 << 22) - (1 << 21);
            endcase
            load_profile(st, en, pick_limit(), pick_limit(), pick_limit());
            quiet = (ph >= 10 && ph < 14);
            repeat (55) query_q.push_back(pick_time());
        end

        drain();
        if (errors == 0) begin
            $display("** trapezoidal_motion_profile: PASSED **");
        end else begin
            $display("** trapezoidal_motion_profile: FAILED **");
        end
        $finish;
    end

endmodule
